// File: hdl/gsm_pkg.sv
package gsm_pkg;

   // Largest number of robots and tasks; sets the store and index widths.
   localparam int MAX_AGENTS = 16;
   localparam int AGENT_W    = $clog2(MAX_AGENTS);
   localparam int COUNT_W    = AGENT_W + 1;
   localparam int ADDR_W     = 2 * AGENT_W;
   localparam int CSR_W      = 5;

   // Request codes carried on req_type.
   localparam logic [1:0] REQ_ROBOT_PREF = 2'd0;
   localparam logic [1:0] REQ_TASK_PREF  = 2'd1;
   localparam logic [1:0] REQ_START      = 2'd2;

   typedef struct packed {
      logic               start;
      logic [1:0]         kind;
      logic [AGENT_W-1:0] row;
      logic [AGENT_W-1:0] pos;
      logic [AGENT_W-1:0] value;
   } req_word_type;

   typedef struct packed {
      logic               valid;
      logic [AGENT_W-1:0] task_id;
      logic [AGENT_W-1:0] robot_id;
      logic               last;
   } rsp_word_type;

   // Number of agents in use: zero acts as one, large values saturate.
   function automatic logic [COUNT_W-1:0] active_count(input logic [CSR_W-1:0] cfg);
      logic [COUNT_W-1:0] n;
      if (cfg == '0) begin
         n = COUNT_W'(1);
      end else if (int'(cfg) > MAX_AGENTS) begin
         n = COUNT_W'(MAX_AGENTS);
      end else begin
         n = COUNT_W'(cfg);
      end
      return n;
   endfunction

endpackage

// File: hdl/gsm_ram.sv
module gsm_ram #(
   parameter int DATA_W = 4,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [2**ADDR_W];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/gsm_engine.sv
module gsm_engine
   import gsm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  req_word_type       req,
   input  logic [COUNT_W-1:0] agent_n,
   output logic               busy,
   output rsp_word_type       rsp
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_FETCH,
      ST_SCAN,
      ST_EMIT
   } state_type;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] depth_ff, depth_in;
   logic [COUNT_W-1:0] n_ff, n_in;
   logic [AGENT_W-1:0] robot_ff, robot_in;
   logic [AGENT_W-1:0] task_ff, task_in;
   logic [AGENT_W-1:0] owner_ff, owner_in;
   logic [AGENT_W-1:0] pos_ff, pos_in;
   logic [AGENT_W-1:0] out_idx_ff, out_idx_in;
   rsp_word_type       rsp_ff, rsp_in;

   // Free robot stack, per-robot next list position, per-task holder.
   logic [AGENT_W-1:0] stack_ff [MAX_AGENTS];
   logic [COUNT_W-1:0] next_ff  [MAX_AGENTS];
   logic               taken_ff [MAX_AGENTS];
   logic [AGENT_W-1:0] holder_ff[MAX_AGENTS];

   logic               restart;
   logic               nc_we;
   logic               claim_en;
   logic               swap_en;
   logic               push_en;
   logic [AGENT_W-1:0] push_val;

   logic               rp_we, tp_we;
   logic [ADDR_W-1:0]  rp_raddr, tp_raddr;
   logic [AGENT_W-1:0] rp_rdata, tp_rdata;

   logic [COUNT_W-1:0] depth_dec;
   logic [AGENT_W-1:0] top_robot;
   logic [COUNT_W-1:0] pop_pos;
   logic [COUNT_W-1:0] scan_next;

   gsm_ram #(.DATA_W(AGENT_W), .ADDR_W(ADDR_W)) u_robot_pref (
      .clock   (clock),
      .wr_en   (rp_we),
      .wr_addr ({req.row, req.pos}),
      .wr_data (req.value),
      .rd_addr (rp_raddr),
      .rd_data (rp_rdata)
   );

   gsm_ram #(.DATA_W(AGENT_W), .ADDR_W(ADDR_W)) u_task_pref (
      .clock   (clock),
      .wr_en   (tp_we),
      .wr_addr ({req.row, req.pos}),
      .wr_data (req.value),
      .rd_addr (tp_raddr),
      .rd_data (tp_rdata)
   );

   assign depth_dec = depth_ff - COUNT_W'(1);
   assign top_robot = stack_ff[depth_dec[AGENT_W-1:0]];
   assign pop_pos   = next_ff[top_robot];
   assign scan_next = {1'b0, pos_ff} + COUNT_W'(1);

   always_comb begin
      state_in   = state_ff;
      depth_in   = depth_ff;
      n_in       = n_ff;
      robot_in   = robot_ff;
      task_in    = task_ff;
      owner_in   = owner_ff;
      pos_in     = pos_ff;
      out_idx_in = out_idx_ff;
      rsp_in     = rsp_ff;
      rsp_in.valid = 1'b0;
      restart    = 1'b0;
      nc_we      = 1'b0;
      claim_en   = 1'b0;
      swap_en    = 1'b0;
      push_en    = 1'b0;
      push_val   = robot_ff;
      rp_we      = 1'b0;
      tp_we      = 1'b0;
      rp_raddr   = {top_robot, pop_pos[AGENT_W-1:0]};
      tp_raddr   = {rp_rdata, {AGENT_W{1'b0}}};
      busy       = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (req.start) begin
               unique case (req.kind)
                  REQ_ROBOT_PREF: rp_we = 1'b1;
                  REQ_TASK_PREF:  tp_we = 1'b1;
                  REQ_START: begin
                     n_in     = agent_n;
                     depth_in = agent_n;
                     restart  = 1'b1;
                     state_in = ST_POP;
                  end
                  default: ;
               endcase
            end
         end

         ST_POP: begin
            if (depth_ff == '0) begin
               out_idx_in = '0;
               state_in   = ST_EMIT;
            end else begin
               depth_in = depth_dec;
               robot_in = top_robot;
               if (pop_pos < n_ff) begin
                  nc_we    = 1'b1;
                  state_in = ST_FETCH;
               end
            end
         end

         ST_FETCH: begin
            state_in = ST_POP;
            if ({1'b0, rp_rdata} >= n_ff) begin
               push_en = 1'b1;
            end else if (!taken_ff[rp_rdata]) begin
               claim_en = 1'b1;
            end else begin
               task_in  = rp_rdata;
               owner_in = holder_ff[rp_rdata];
               pos_in   = '0;
               state_in = ST_SCAN;
            end
         end

         ST_SCAN: begin
            tp_raddr = {task_ff, scan_next[AGENT_W-1:0]};
            if (tp_rdata == owner_ff) begin
               push_en  = 1'b1;
               state_in = ST_POP;
            end else if (tp_rdata == robot_ff) begin
               swap_en  = 1'b1;
               push_en  = 1'b1;
               push_val = owner_ff;
               state_in = ST_POP;
            end else if (scan_next >= n_ff) begin
               push_en  = 1'b1;
               state_in = ST_POP;
            end else begin
               pos_in = scan_next[AGENT_W-1:0];
            end
         end

         ST_EMIT: begin
            rsp_in.valid    = 1'b1;
            rsp_in.task_id  = out_idx_ff;
            rsp_in.robot_id = taken_ff[out_idx_ff] ? holder_ff[out_idx_ff] : '0;
            rsp_in.last     = ({1'b0, out_idx_ff} == n_ff - COUNT_W'(1));
            out_idx_in      = out_idx_ff + AGENT_W'(1);
            if (rsp_in.last) begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // Pushes only happen in states that do not pop.
      if (push_en) begin
         depth_in = depth_ff + COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         depth_ff     <= COUNT_W'(MAX_AGENTS);
         n_ff         <= COUNT_W'(MAX_AGENTS);
         rsp_ff.valid <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         n_ff         <= n_in;
         rsp_ff.valid <= rsp_in.valid;
      end
      robot_ff        <= robot_in;
      task_ff         <= task_in;
      owner_ff        <= owner_in;
      pos_ff          <= pos_in;
      out_idx_ff      <= out_idx_in;
      rsp_ff.task_id  <= rsp_in.task_id;
      rsp_ff.robot_id <= rsp_in.robot_id;
      rsp_ff.last     <= rsp_in.last;
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         for (int i = 0; i < MAX_AGENTS; i++) begin
            next_ff[i]  <= '0;
            taken_ff[i] <= 1'b0;
         end
      end else begin
         if (nc_we) begin
            next_ff[top_robot] <= pop_pos + COUNT_W'(1);
         end
         if (claim_en) begin
            taken_ff[rp_rdata] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (restart) begin
         for (int i = 0; i < MAX_AGENTS; i++) begin
            stack_ff[i] <= AGENT_W'(agent_n - COUNT_W'(1) - COUNT_W'(i));
         end
      end else if (push_en) begin
         stack_ff[depth_ff[AGENT_W-1:0]] <= push_val;
      end
      if (claim_en) begin
         holder_ff[rp_rdata] <= robot_ff;
      end else if (swap_en) begin
         holder_ff[task_ff] <= robot_ff;
      end
   end

   assign rsp = rsp_ff;

endmodule

// File: hdl/stable_matching_engine.sv
// A preference load word is handled while idle, and loads may follow back to back.
// A start word runs up to n*n proposals; each takes a stack pop and a robot list read,
// plus a scan of up to n task list entries when the task is held, and a robot whose
// list is used up costs only a pop. After the pop that finds the stack empty, the
// emit state and then the registered result follow: n words, one per cycle, task 0
// first; the receiver cannot stall them and busy drops while the last one is shown.
module stable_matching_engine
   import gsm_pkg::*;
(
   input  logic               clock,
   input  logic               reset,

   // Request channel: a word is taken when start is high and busy is low.
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_type,
   input  logic [AGENT_W-1:0] req_row_index,
   input  logic [AGENT_W-1:0] req_list_position,
   input  logic [AGENT_W-1:0] req_entry_value,

   // Result channel: one word per cycle while rsp_valid is high, never stalled.
   output logic               rsp_valid,
   output logic [AGENT_W-1:0] rsp_task_id,
   output logic [AGENT_W-1:0] rsp_robot_id,
   output logic               rsp_last,

   // Configuration channel: the agent count register.
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [CSR_W-1:0]   csr_agent_count
);

   // Reset is synchronous and active high: the agent count returns to 16 and the
   // block goes idle; preference memories keep their contents until rewritten.
   logic [CSR_W-1:0] agent_count_ff, agent_count_in;
   req_word_type     req;
   rsp_word_type     rsp;

   // The count register is only written while no matching run is in flight,
   // so the engine samples a stable value when a start word arrives.
   assign csr_ready = !busy;

   always_comb begin
      agent_count_in = agent_count_ff;
      if (csr_valid && csr_ready) begin
         agent_count_in = csr_agent_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         agent_count_ff <= CSR_W'(16);
      end else begin
         agent_count_ff <= agent_count_in;
      end
   end

   // Gather the request word; the engine decodes the request code.
   assign req.start = start;
   assign req.kind  = req_type;
   assign req.row   = req_row_index;
   assign req.pos   = req_list_position;
   assign req.value = req_entry_value;

   gsm_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .req     (req),
      .agent_n (active_count(agent_count_ff)),
      .busy    (busy),
      .rsp     (rsp)
   );

   assign rsp_valid    = rsp.valid;
   assign rsp_task_id  = rsp.task_id;
   assign rsp_robot_id = rsp.robot_id;
   assign rsp_last     = rsp.last;

endmodule

// File: hdl/gsm_checker.sv
module gsm_checker
   import gsm_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [1:0]         req_type,
   input logic               rsp_valid,
   input logic [AGENT_W-1:0] rsp_task_id,
   input logic               rsp_last,
   input logic               csr_valid,
   input logic               csr_ready
);

   // A result run has no gaps.
   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid)
      else $error("result run broke before its last word");

   // Tasks come out in ascending order.
   a_task_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_task_id == $past(rsp_task_id) + AGENT_W'(1))
      else $error("task order skipped");

   // A run starts at task zero.
   a_run_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !$past(rsp_valid) |-> rsp_task_id == '0)
      else $error("result run did not start at task zero");

   // A start word makes the block busy, and no result word is shown as it begins.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_type == REQ_START |=> busy && !rsp_valid)
      else $error("start word did not begin a run");

   // The agent count is only taken while the block is idle.
   a_cfg_idle: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_ready |-> !busy)
      else $error("agent count written during a run");

endmodule

bind stable_matching_engine gsm_checker u_gsm_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_type  (req_type),
   .rsp_valid (rsp_valid),
   .rsp_task_id (rsp_task_id),
   .rsp_last  (rsp_last),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready)
);

// File: verif/tb_stable_matching_engine.sv
module tb_stable_matching_engine;
   import gsm_pkg::*;

   // The fourth request code has no meaning; the block must drop such a word.
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // Loads are written while the block is idle, so the LOAD_SETTLE wait after the
   // last result covers any load still in flight before the agent count is rewritten.
   localparam int LOAD_SETTLE  = 4;
   // Hard limit on simulated cycles; reaching it ends the simulation as a failure.
   localparam int LIMIT_CYCLES = 400_000;
   // Random words to send after the directed part, not counting ignored ones.
   localparam int RANDOM_WORDS = 300;

   // One matched pair as it leaves the block.
   typedef struct {
      logic [AGENT_W-1:0] task_id;
      logic [AGENT_W-1:0] robot_id;
      logic               last;
   } pair_word_type;

   // One row of the directed stimulus. When typed is set, the pairs for a
   // start word are written here (at most two tasks) rather than predicted.
   typedef struct packed {
      logic               set_count;
      logic [CSR_W-1:0]   count;
      logic [1:0]         kind;
      logic [AGENT_W-1:0] row;
      logic [AGENT_W-1:0] pos;
      logic [AGENT_W-1:0] value;
      logic               typed;
      logic [AGENT_W-1:0] robot0;
      logic [AGENT_W-1:0] robot1;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 24;
   localparam directed_row_type DIRECTED[DIRECTED_ROWS] = '{
      // Agent count 0 acts as one agent: robot 0 takes task 0.
      '{1'b1, 5'd0, REQ_ROBOT_PREF, 4'd0, 4'd0, 4'd0, 1'b0, 4'd0, 4'd0},
      '{1'b0, 5'd0, REQ_TASK_PREF, 4'd0, 4'd0, 4'd0, 1'b0, 4'd0, 4'd0},
      '{1'b0, 5'd0, REQ_START, 4'd0, 4'd0, 4'd0, 1'b1, 4'd0, 4'd0},
      // Robot 0 lists a task that does not exist, wastes its only proposal and
      // drops out; the lone task stays unmatched and reports robot 0.
      '{1'b0, 5'd0, REQ_ROBOT_PREF, 4'd0, 4'd0, 4'd15, 1'b0, 4'd0, 4'd0},
      '{1'b0, 5'd0, REQ_START, 4'd0, 4'd0, 4'd0, 1'b1, 4'd0, 4'd0},
      // Two agents, both robots want task 1, and task 1 prefers robot 1.
      // Robot 0 is bumped and falls back to task 0.
      '{1'b1, 5'd2, REQ_ROBOT_PREF, 4'd0, 4'd0, 4'd1, 1'b0, 4'd0, 4'd0},
      '{1'b0, 5'd0, REQ_ROBOT_PREF, 4'd0, 4'd1, 4'd0, 1'b0, 4'd0, 4'd0},
      '{1'b0, 5'd0, REQ_ROBOT_PREF, 4'd1, 4'd0, 4'd1, 1'b0, 4'd0, 4'd0},
      '{1'b0, 5'd0, REQ_ROBOT_PREF, 4'd1, 4'd1, 4'd0, 1'b0, 4'd0, 4'd0},
      '{1'b0, 5'd0, REQ_TASK_PREF, 4'd0, 4'd0, 4'd0, 1'b0, 4'd0, 4'd0},
      '{1'b0, 5'd0, REQ_TASK_PREF, 4'd0, 4'd1, 4'd1, 1'b0, 4'd0, 4'd0},
      '{1'b0, 5'd0, REQ_TASK_PREF, 4'd1, 4'd0, 4'd1, 1'b0, 4'd0, 4'd0},
      '{1'b0, 5'd0, REQ_TASK_PREF, 4'd1, 4'd1, 4'd0, 1'b0, 4'd0, 4'd0},
      '{1'b0, 5'd0, REQ_START, 4'd0, 4'd0, 4'd0, 1'b1, 4'd0, 4'd1},
      // Task 1 lists neither robot, so both rank last and tie: the owner
      // (robot 0) stays and robot 1 moves on to task 0.
      '{1'b0, 5'd0, REQ_TASK_PREF, 4'd1, 4'd0, 4'd15, 1'b0, 4'd0, 4'd0},
      '{1'b0, 5'd0, REQ_TASK_PREF, 4'd1, 4'd1, 4'd15, 1'b0, 4'd0, 4'd0},
      '{1'b0, 5'd0, REQ_START, 4'd0, 4'd0, 4'd0, 1'b1, 4'd1, 4'd0},
      // Field extremes: an unused request code, then the far corner of both stores.
      '{1'b0, 5'd0, REQ_UNUSED, 4'd15, 4'd15, 4'd15, 1'b0, 4'd0, 4'd0},
      '{1'b0, 5'd0, REQ_ROBOT_PREF, 4'd15, 4'd15, 4'd15, 1'b0, 4'd0, 4'd0},
      '{1'b0, 5'd0, REQ_TASK_PREF, 4'd15, 4'd15, 4'd15, 1'b0, 4'd0, 4'd0},
      // Robot 0 lists task 1 twice, loses it both times and runs out of list;
      // task 0 is left unmatched.
      '{1'b0, 5'd0, REQ_ROBOT_PREF, 4'd0, 4'd1, 4'd1, 1'b0, 4'd0, 4'd0},
      '{1'b0, 5'd0, REQ_TASK_PREF, 4'd1, 4'd0, 4'd1, 1'b0, 4'd0, 4'd0},
      '{1'b0, 5'd0, REQ_TASK_PREF, 4'd1, 4'd1, 4'd0, 1'b0, 4'd0, 4'd0},
      '{1'b0, 5'd0, REQ_START, 4'd0, 4'd0, 4'd0, 1'b1, 4'd0, 4'd1}
   };

   // Every input is at a known value from time zero.
   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_type = REQ_ROBOT_PREF;
   logic [AGENT_W-1:0] req_row_index = '0;
   logic [AGENT_W-1:0] req_list_position = '0;
   logic [AGENT_W-1:0] req_entry_value = '0;
   logic               rsp_valid;
   logic [AGENT_W-1:0] rsp_task_id;
   logic [AGENT_W-1:0] rsp_robot_id;
   logic               rsp_last;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [CSR_W-1:0]   csr_agent_count = '0;

   stable_matching_engine DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_type          (req_type),
      .req_row_index     (req_row_index),
      .req_list_position (req_list_position),
      .req_entry_value   (req_entry_value),
      .rsp_valid         (rsp_valid),
      .rsp_task_id       (rsp_task_id),
      .rsp_robot_id      (rsp_robot_id),
      .rsp_last          (rsp_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_agent_count   (csr_agent_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Shadow copy of the block's state, kept in step with every accepted word.
   // ------------------------------------------------------------------------
   logic [AGENT_W-1:0] robot_lists [16][16];
   logic [AGENT_W-1:0] task_lists  [16][16];
   // Which list entries have been written at least once. The block's stores
   // come up undefined, so a start is only sent once every entry it can read
   // has been loaded.
   bit                 robot_loaded [16][16];
   bit                 task_loaded  [16][16];
   logic [CSR_W-1:0]   agent_count_shadow = 5'd16;
   logic [4:0]         next_pos [16];
   logic [AGENT_W-1:0] task_holder [16];
   bit                 task_held [16];
   logic [AGENT_W-1:0] free_robots [16];
   int                 free_depth;

   // Matched pairs still owed by the block, oldest first.
   pair_word_type      pending_pairs [$];
   int                 fail_count;
   int                 words_sent;
   int                 cycle_count;
   bit                 no_gaps;

   // The agent count in use: zero acts as one, anything past the store size
   // saturates at the store size.
   function automatic int active_agents();
      int n;
      n = int'(agent_count_shadow);
      if (n == 0) n = 1;
      if (n > MAX_AGENTS) n = MAX_AGENTS;
      return n;
   endfunction

   // Where robot r sits in task t's list; a robot that is not listed ranks
   // behind everyone who is.
   function automatic int rank_in_list(input int t, input int r, input int n);
      for (int p = 0; p < n; p++) begin
         if (int'(task_lists[t][p]) == r) return p;
      end
      return n;
   endfunction

   // Robot-proposing deferred acceptance. Free robots sit on a stack with
   // robot 0 on top; a robot that is turned down or wastes a proposal on a
   // task that does not exist goes back on top, and a robot that has used
   // up its list simply drops off.
   function automatic void match_proposals();
      int n;
      int r;
      int p;
      int t;
      int loser;
      n = active_agents();
      for (int i = 0; i < 16; i++) begin
         next_pos[i]  = '0;
         task_held[i] = 1'b0;
      end
      for (int i = 0; i < n; i++) free_robots[i] = AGENT_W'(n - 1 - i);
      free_depth = n;
      while (free_depth > 0) begin
         free_depth--;
         r = int'(free_robots[free_depth]);
         p = int'(next_pos[r]);
         if (p >= n) continue;
         t = int'(robot_lists[r][p]);
         next_pos[r] = 5'(p + 1);
         if (t >= n) begin
            free_robots[free_depth] = AGENT_W'(r);
            free_depth++;
         end else if (!task_held[t]) begin
            task_held[t]   = 1'b1;
            task_holder[t] = AGENT_W'(r);
         end else begin
            loser = r;
            // On a tie the current holder keeps the task.
            if (rank_in_list(t, r, n) < rank_in_list(t, int'(task_holder[t]), n)) begin
               loser = int'(task_holder[t]);
               task_holder[t] = AGENT_W'(r);
            end
            free_robots[free_depth] = AGENT_W'(loser);
            free_depth++;
         end
      end
   endfunction

   // Applies one accepted word to the shadow state and queues the pairs that
   // a start word owes: one per task in task order, the final one marked last.
   function automatic void take_word(input logic [1:0] kind, input logic [AGENT_W-1:0] row,
                                     input logic [AGENT_W-1:0] pos,
                                     input logic [AGENT_W-1:0] value, input bit typed,
                                     input logic [AGENT_W-1:0] robot0,
                                     input logic [AGENT_W-1:0] robot1);
      int n;
      pair_word_type pair;
      case (kind)
         REQ_ROBOT_PREF: begin
            robot_lists[row][pos]  = value;
            robot_loaded[row][pos] = 1'b1;
         end
         REQ_TASK_PREF: begin
            task_lists[row][pos]  = value;
            task_loaded[row][pos] = 1'b1;
         end
         REQ_START: begin
            match_proposals();
            n = active_agents();
            for (int t = 0; t < n; t++) begin
               pair.task_id = AGENT_W'(t);
               pair.last    = (t == n - 1);
               if (typed) begin
                  pair.robot_id = (t == 0) ? robot0 : robot1;
               end else begin
                  pair.robot_id = task_held[t] ? task_holder[t] : '0;
               end
               pending_pairs.push_back(pair);
            end
         end
         default: ;
      endcase
      if (kind != REQ_UNUSED) words_sent++;
   endfunction

   // ------------------------------------------------------------------------
   // Request side.
   // ------------------------------------------------------------------------

   // Sends one word after a random gap (none in a burst stretch) and holds it
   // until the block takes it. Start is only lowered when a gap follows, so a
   // back-to-back word never sees start dropped and raised in the same step.
   task automatic send_word(input logic [1:0] kind, input logic [AGENT_W-1:0] row,
                            input logic [AGENT_W-1:0] pos, input logic [AGENT_W-1:0] value,
                            input bit typed = 1'b0, input logic [AGENT_W-1:0] robot0 = '0,
                            input logic [AGENT_W-1:0] robot1 = '0);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start             <= 1'b1;
      req_type          <= kind;
      req_row_index     <= row;
      req_list_position <= pos;
      req_entry_value   <= value;
      @(posedge clock);
      while (busy) @(posedge clock);
      take_word(kind, row, pos, value, typed, robot0, robot1);
   endtask

   // Stops sending and waits until the block owes nothing and has gone idle.
   task automatic drain_results();
      start <= 1'b0;
      while (pending_pairs.size() != 0) @(posedge clock);
      repeat (LOAD_SETTLE) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   // The agent count is only rewritten with the block idle.
   task automatic set_agent_count(input logic [CSR_W-1:0] count);
      drain_results();
      csr_valid       <= 1'b1;
      csr_agent_count <= count;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      agent_count_shadow = count;
   endtask

   // Loads one whole list as a shuffled permutation; now and then an entry is
   // replaced by any value, which gives duplicates, missing robots and tasks
   // past the agent count.
   task automatic load_list(input logic [1:0] kind, input int row, input int n);
      int order[16];
      int swap_with;
      int held_value;
      for (int j = 0; j < n; j++) order[j] = j;
      for (int j = n - 1; j > 0; j--) begin
         swap_with        = $urandom_range(0, j);
         held_value       = order[j];
         order[j]         = order[swap_with];
         order[swap_with] = held_value;
      end
      for (int j = 0; j < n; j++) begin
         if ($urandom_range(0, 9) == 0) order[j] = $urandom_range(0, 15);
         send_word(kind, AGENT_W'(row), AGENT_W'(j), AGENT_W'(order[j]));
      end
   endtask

   // Writes every entry a start with n agents can read that was never written.
   task automatic fill_unwritten(input int n);
      for (int r = 0; r < n; r++) begin
         for (int p = 0; p < n; p++) begin
            if (!robot_loaded[r][p]) begin
               send_word(REQ_ROBOT_PREF, AGENT_W'(r), AGENT_W'(p),
                         AGENT_W'($urandom_range(0, n - 1)));
            end
            if (!task_loaded[r][p]) begin
               send_word(REQ_TASK_PREF, AGENT_W'(r), AGENT_W'(p),
                         AGENT_W'($urandom_range(0, n - 1)));
            end
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Result side: the block cannot be stalled, so every strobe is a word.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      pair_word_type want;
      if (!reset && rsp_valid) begin
         if (pending_pairs.size() == 0) begin
            fail_count++;
            $display("%0t: unexpected pair: task %0d robot %0d last %0b", $time,
                     rsp_task_id, rsp_robot_id, rsp_last);
         end else begin
            want = pending_pairs.pop_front();
            if (rsp_task_id !== want.task_id) begin
               fail_count++;
               $display("%0t: task_id expected %0d actual %0d", $time, want.task_id,
                        rsp_task_id);
            end
            if (rsp_robot_id !== want.robot_id) begin
               fail_count++;
               $display("%0t: robot_id for task %0d expected %0d actual %0d", $time,
                        want.task_id, want.robot_id, rsp_robot_id);
            end
            if (rsp_last !== want.last) begin
               fail_count++;
               $display("%0t: last for task %0d expected %0b actual %0b", $time,
                        want.task_id, want.last, rsp_last);
            end
         end
      end
   end

   // Hard stop in case the block hangs or never answers.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus.
   // ------------------------------------------------------------------------
   initial begin
      directed_row_type step;
      int n;
      int style;
      int pick;
      int target;
      logic [1:0] noise_kind;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: hand-checked cases with one or two agents.
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         step = DIRECTED[i];
         if (step.set_count) set_agent_count(step.count);
         send_word(step.kind, step.row, step.pos, step.value, step.typed, step.robot0,
                   step.robot1);
      end

      // Random part. Each round picks a small agent count, then loads
      // well-formed lists with random content, or scribbles over the lists,
      // or sends dropped words and writes anywhere in the stores. Then it tops up
      // any entry never written and starts the matching once or twice.
      target = words_sent + RANDOM_WORDS;
      while (words_sent < target) begin
         pick = $urandom_range(0, 9);
         set_agent_count((pick == 0) ? 5'd0 : CSR_W'($urandom_range(1, 6)));
         n = active_agents();
         no_gaps = ($urandom_range(0, 3) == 0);
         style = $urandom_range(0, 9);
         if (style <= 6) begin
            for (int r = 0; r < n; r++) begin
               if ($urandom_range(0, 3) != 0) load_list(REQ_ROBOT_PREF, r, n);
            end
            for (int t = 0; t < n; t++) begin
               if ($urandom_range(0, 3) != 0) load_list(REQ_TASK_PREF, t, n);
            end
         end else if (style == 7) begin
            repeat ($urandom_range(1, 2 * n)) begin
               send_word($urandom_range(0, 1) ? REQ_TASK_PREF : REQ_ROBOT_PREF,
                         AGENT_W'($urandom_range(0, n - 1)),
                         AGENT_W'($urandom_range(0, n - 1)),
                         AGENT_W'($urandom_range(0, 15)));
            end
         end else begin
            // Noise: dropped request codes and writes anywhere in the stores.
            repeat ($urandom_range(1, 6)) begin
               noise_kind = 2'($urandom_range(0, 3));
               if (noise_kind == REQ_START) noise_kind = REQ_UNUSED;
               send_word(noise_kind,
                         AGENT_W'($urandom_range(0, 15)), AGENT_W'($urandom_range(0, 15)),
                         AGENT_W'($urandom_range(0, 15)));
            end
         end
         fill_unwritten(n);
         repeat ($urandom_range(1, 2)) send_word(REQ_START, '0, '0, '0);
         // Now and then hold off until the block has paid out everything.
         if ($urandom_range(0, 3) == 0) drain_results();
      end

      // Largest size, reached through a saturating count and then the exact one.
      // Every robot puts a different task first, so each first proposal lands and
      // no other list entry is read.
      set_agent_count(5'd31);
      no_gaps = 1'b0;
      for (int r = 0; r < MAX_AGENTS; r++) begin
         send_word(REQ_ROBOT_PREF, AGENT_W'(r), '0, AGENT_W'(r));
      end
      send_word(REQ_START, '0, '0, '0);
      set_agent_count(5'd16);
      for (int r = 0; r < MAX_AGENTS; r++) begin
         send_word(REQ_ROBOT_PREF, AGENT_W'(r), '0, AGENT_W'(MAX_AGENTS - 1 - r));
      end
      send_word(REQ_START, '0, '0, '0);

      drain_results();
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
